FILE: rtl/pde_pkg.sv
// ----------------------------------------------------------------------------
// pde_pkg
// Shared widths, register indexes, the pipeline word type and the factor
// table used by the polynomial and derivative evaluator.
// ----------------------------------------------------------------------------
package pde_pkg;

   localparam int DEGREE        = 5;
   localparam int NUM_STEPS     = DEGREE + 1;
   localparam int NUM_COEF_REGS = 6;

   localparam int COEF_W    = 48;
   localparam int TIME_W    = 32;
   localparam int ACC_W     = 64;
   localparam int HALF_W    = 32;
   localparam int FRAC_W    = 24;
   localparam int ORDER_W   = 3;
   localparam int IDX_W     = 3;
   localparam int FAC_W     = 7;
   localparam int CSR_IDX_W = 3;
   localparam int EPROD_W   = COEF_W + FAC_W + 1;

   localparam logic [ORDER_W-1:0] MAX_ORDER = 3'd5;

   // Register indexes; indexes below NUM_COEF_REGS select a coefficient.
   localparam logic [CSR_IDX_W-1:0] REG_DERIV_COUNT   = 3'd6;
   localparam logic [ORDER_W-1:0]   DERIV_COUNT_RESET = 3'd2;

   localparam logic signed [ACC_W-1:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [ACC_W-1:0] ACC_MIN = 64'sh8000_0000_0000_0000;

   typedef logic [NUM_COEF_REGS-1:0][COEF_W-1:0] coef_arr_type;

   // One evaluation in flight: the running Horner sum of one derivative order.
   typedef struct packed {
      logic [TIME_W-1:0]       t;
      logic [ORDER_W-1:0]      order;
      logic                    last;
      logic                    sat;
      logic signed [ACC_W-1:0] acc;
   } job_type;

   // Multiplier that turns coefficient j+k into term j of the k-th derivative:
   // (j+k)! / j!. Zero where the source coefficient does not exist.
   function automatic logic [FAC_W-1:0] coef_factor(input logic [IDX_W-1:0]   j,
                                                    input logic [ORDER_W-1:0] k);
      logic [15:0] f;
      int          top;
      top = int'(j) + int'(k);
      f   = 16'd1;
      for (int i = 1; i <= int'(MAX_ORDER); i++) begin
         if (i <= int'(k)) begin
            f = 16'(f * 16'(int'(j) + i));
         end
      end
      if (top >= NUM_COEF_REGS || top > DEGREE) begin
         f = 16'd0;
      end
      return f[FAC_W-1:0];
   endfunction

endpackage

FILE: rtl/polynomial_and_derivatives_eval.sv
// ----------------------------------------------------------------------------
// polynomial_and_derivatives_eval
// Evaluates a quintic polynomial and its successive derivatives at a Q8.24
// time, giving saturated Q40.24 results, one word per derivative order.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake          Word
//   req_      in         valid / ready      sample_time
//   rsp_      out        valid / ready      result_value, deriv_order,
//                                           last_of_run, saturated
//   csr_      in         write enable only  index, 48-bit data
//
// A time word occupies the issue register while it issues one job per order,
// derivative_count + 1 jobs (1 to 6); the next word is taken as the last order
// issues. Each order passes six Horner steps of four stages each and then the
// result register; the orders of one time word leave in turn, value first.
// Reset clears the coefficients to zero and the derivative count to two. The
// whole pipeline holds while the result register is full and not taken; no
// job is lost or repeated.
module polynomial_and_derivatives_eval (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [pde_pkg::TIME_W-1:0]          req_sample_time,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [pde_pkg::ACC_W-1:0]    rsp_result_value,
   output logic [pde_pkg::ORDER_W-1:0]         rsp_deriv_order,
   output logic                                rsp_last_of_run,
   output logic                                rsp_saturated,
   input  logic                                csr_we,
   input  logic [pde_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pde_pkg::COEF_W-1:0]          csr_wdata
);

   pde_pkg::coef_arr_type         coeff_ff, coeff_in;
   logic [pde_pkg::ORDER_W-1:0]   dcount_ff, dcount_in;

   logic                          adv;
   logic                          stage_valid [pde_pkg::NUM_STEPS+1];
   pde_pkg::job_type              stage_job   [pde_pkg::NUM_STEPS+1];

   logic                          rsp_valid_ff, rsp_valid_in;
   pde_pkg::job_type              rsp_job_ff;

   always_comb begin
      coeff_in  = coeff_ff;
      dcount_in = dcount_ff;
      if (csr_we) begin
         if (csr_index < pde_pkg::NUM_COEF_REGS) begin
            coeff_in[csr_index] = csr_wdata;
         end else if (csr_index == pde_pkg::REG_DERIV_COUNT) begin
            dcount_in = csr_wdata[pde_pkg::ORDER_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff  <= '0;
         dcount_ff <= pde_pkg::DERIV_COUNT_RESET;
      end else begin
         coeff_ff  <= coeff_in;
         dcount_ff <= dcount_in;
      end
   end

   assign adv = !rsp_valid_ff || rsp_ready;

   pde_issue u_issue (
      .clock           (clock),
      .reset           (reset),
      .adv             (adv),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_time (req_sample_time),
      .deriv_count     (dcount_ff),
      .job_valid       (stage_valid[0]),
      .job             (stage_job[0])
   );

   // Steps run from the highest coefficient down; the sum starts at zero.
   for (genvar s = 0; s < pde_pkg::NUM_STEPS; s++) begin : g_step
      pde_step u_step (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .step_idx  (pde_pkg::IDX_W'(pde_pkg::DEGREE - s)),
         .coeff     (coeff_ff),
         .in_valid  (stage_valid[s]),
         .in_job    (stage_job[s]),
         .out_valid (stage_valid[s+1]),
         .out_job   (stage_job[s+1])
      );
   end

   assign rsp_valid_in = adv ? stage_valid[pde_pkg::NUM_STEPS] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (adv) begin
         rsp_job_ff <= stage_job[pde_pkg::NUM_STEPS];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_job_ff.acc;
   assign rsp_deriv_order  = rsp_job_ff.order;
   assign rsp_last_of_run  = rsp_job_ff.last;
   assign rsp_saturated    = rsp_job_ff.sat;

endmodule

FILE: rtl/pde_issue.sv
// ----------------------------------------------------------------------------
// pde_issue
// Holds one accepted time word and issues one job per derivative order,
// value first, into the Horner pipeline.
// ----------------------------------------------------------------------------
module pde_issue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [pde_pkg::TIME_W-1:0]    req_sample_time,
   input  logic [pde_pkg::ORDER_W-1:0]   deriv_count,
   output logic                          job_valid,
   output pde_pkg::job_type              job
);

   logic                        busy_ff, busy_in;
   logic [pde_pkg::TIME_W-1:0]  t_ff, t_in;
   logic [pde_pkg::ORDER_W-1:0] count_ff, count_in;
   logic [pde_pkg::ORDER_W-1:0] order_ff, order_in;
   logic                        last_job;
   logic                        accept;

   assign last_job  = (order_ff == count_ff);
   assign req_ready = !busy_ff || (adv && last_job);
   assign accept    = req_valid && req_ready;

   always_comb begin
      busy_in  = busy_ff;
      t_in     = t_ff;
      count_in = count_ff;
      order_in = order_ff;
      if (accept) begin
         busy_in  = 1'b1;
         t_in     = req_sample_time;
         count_in = (deriv_count > pde_pkg::MAX_ORDER) ? pde_pkg::MAX_ORDER : deriv_count;
         order_in = '0;
      end else if (busy_ff && adv) begin
         if (last_job) begin
            busy_in = 1'b0;
         end else begin
            order_in = order_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      t_ff     <= t_in;
      count_ff <= count_in;
      order_ff <= order_in;
   end

   assign job_valid = busy_ff;

   always_comb begin
      job       = '0;
      job.t     = t_ff;
      job.order = order_ff;
      job.last  = last_job;
   end

endmodule

FILE: rtl/pde_step.sv
// ----------------------------------------------------------------------------
// pde_step
// One Horner step in four stages: magnitude, partial products, rounding with
// saturation, saturating add of the derivative coefficient for this step.
// ----------------------------------------------------------------------------
module pde_step (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             adv,
   input  logic [pde_pkg::IDX_W-1:0]        step_idx,
   input  pde_pkg::coef_arr_type            coeff,
   input  logic                             in_valid,
   input  pde_pkg::job_type                 in_job,
   output logic                             out_valid,
   output pde_pkg::job_type                 out_job
);

   localparam int HI_SHIFT = pde_pkg::HALF_W - pde_pkg::FRAC_W;
   localparam logic [pde_pkg::ACC_W-1:0] ROUND_HALF = 64'd1 << (pde_pkg::FRAC_W - 1);
   localparam logic [pde_pkg::ACC_W-1:0] NEG_LIMIT  = 64'h8000_0000_0000_0000;

   // Stage 1
   logic                                v1_ff;
   pde_pkg::job_type                    job1_ff;
   logic                                neg1_ff, neg1_in;
   logic [pde_pkg::ACC_W-1:0]           mag1_ff, mag1_in;
   logic signed [pde_pkg::COEF_W-1:0]   cf1_ff, cf1_in;
   logic [pde_pkg::FAC_W-1:0]           fac1_ff, fac1_in;
   logic [pde_pkg::IDX_W:0]             csum;

   // Stage 2
   logic                                v2_ff;
   pde_pkg::job_type                    job2_ff;
   logic                                neg2_ff;
   logic [pde_pkg::ACC_W-1:0]           lo2_ff, lo2_in;
   logic [pde_pkg::ACC_W-1:0]           hi2_ff, hi2_in;
   logic signed [pde_pkg::EPROD_W-1:0]  e2_ff, e2_in;

   // Stage 3
   logic                                v3_ff;
   pde_pkg::job_type                    job3_ff, job3_in;
   logic signed [pde_pkg::EPROD_W-1:0]  e3_ff;
   logic                                hi_ovf;
   logic [pde_pkg::ACC_W-1:0]           r3;

   // Stage 4
   logic                                v4_ff;
   pde_pkg::job_type                    job4_ff, job4_in;
   logic signed [pde_pkg::ACC_W:0]      sum4;

   always_comb begin
      neg1_in = in_job.acc[pde_pkg::ACC_W-1];
      mag1_in = neg1_in ? (~in_job.acc + 1'b1) : in_job.acc;
      csum    = {1'b0, step_idx} + {1'b0, in_job.order};
      cf1_in  = '0;
      if (csum < pde_pkg::NUM_COEF_REGS) begin
         cf1_in = coeff[csum[pde_pkg::IDX_W-1:0]];
      end
      fac1_in = pde_pkg::coef_factor(step_idx, in_job.order);
   end

   always_comb begin
      lo2_in = mag1_ff[pde_pkg::HALF_W-1:0] * job1_ff.t;
      hi2_in = mag1_ff[pde_pkg::ACC_W-1:pde_pkg::HALF_W] * job1_ff.t;
      e2_in  = cf1_ff * $signed({1'b0, fac1_ff});
   end

   // The high partial product is worth 2^(HALF_W - FRAC_W) after scaling; any
   // bit at or above 2^55 means the magnitude no longer fits.
   always_comb begin
      hi_ovf  = |hi2_ff[pde_pkg::ACC_W-1:pde_pkg::ACC_W-1-HI_SHIFT];
      r3      = {hi2_ff[pde_pkg::ACC_W-HI_SHIFT-1:0], {HI_SHIFT{1'b0}}}
              + ((lo2_ff + ROUND_HALF) >> pde_pkg::FRAC_W);
      job3_in = job2_ff;
      if (hi_ovf) begin
         job3_in.sat = 1'b1;
         job3_in.acc = neg2_ff ? pde_pkg::ACC_MIN : pde_pkg::ACC_MAX;
      end else if (neg2_ff) begin
         if (r3 > NEG_LIMIT) begin
            job3_in.sat = 1'b1;
            job3_in.acc = pde_pkg::ACC_MIN;
         end else begin
            job3_in.acc = ~r3 + 1'b1;
         end
      end else if (r3[pde_pkg::ACC_W-1]) begin
         job3_in.sat = 1'b1;
         job3_in.acc = pde_pkg::ACC_MAX;
      end else begin
         job3_in.acc = r3;
      end
   end

   always_comb begin
      sum4    = {job3_ff.acc[pde_pkg::ACC_W-1], job3_ff.acc}
              + (pde_pkg::ACC_W + 1)'(e3_ff);
      job4_in = job3_ff;
      if (sum4[pde_pkg::ACC_W] != sum4[pde_pkg::ACC_W-1]) begin
         job4_in.sat = 1'b1;
         job4_in.acc = sum4[pde_pkg::ACC_W] ? pde_pkg::ACC_MIN : pde_pkg::ACC_MAX;
      end else begin
         job4_in.acc = sum4[pde_pkg::ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      if (adv) begin
         job1_ff <= in_job;
         neg1_ff <= neg1_in;
         mag1_ff <= mag1_in;
         cf1_ff  <= cf1_in;
         fac1_ff <= fac1_in;
         job2_ff <= job1_ff;
         neg2_ff <= neg1_ff;
         lo2_ff  <= lo2_in;
         hi2_ff  <= hi2_in;
         e2_ff   <= e2_in;
         job3_ff <= job3_in;
         e3_ff   <= e2_ff;
         job4_ff <= job4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_job   = job4_ff;

endmodule
